// ----- hw/rtl/skcp_pkg.sv -----
// shared types, constants and helpers of the skyline contour packer
package skcp_pkg;

  localparam int unsigned CW = 31;
  localparam logic [CW-1:0] COORD_MAX = {CW{1'b1}};

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t start;
    coord_t level;
    coord_t length;
  } seg_t;

  typedef struct packed {
    logic valid;
    seg_t seg;
  } piece_t;

  // per-cycle controls shared by every cell of the row
  typedef struct packed {
    logic ground;
    logic rotate;
    logic push;
    logic commit;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TOP,
    ST_BUILD,
    ST_FINBLK,
    ST_DRAIN,
    ST_FLUSH,
    ST_PAD,
    ST_COMMIT,
    ST_DONE
  } state_t;

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? COORD_MAX : s[CW-1:0];
  endfunction

endpackage

// ----- hw/rtl/skcp_cell.sv -----
// one cell of the segment row: a live segment and a segment of the list being rebuilt
module skcp_cell import skcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  seg_t       ground_seg,
  input  seg_t       old_in,
  input  seg_t       new_in,
  output seg_t       old_seg,
  output seg_t       new_seg
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.ground) begin
      old_seg <= ground_seg;
    end else if (ctrl.commit) begin
      old_seg <= new_seg;
    end else if (ctrl.rotate) begin
      old_seg <= old_in;
    end
  end

  // rebuilt list shifts toward the head on each push
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      new_seg <= new_in;
    end
  end

endmodule

// ----- hw/rtl/skyline_contour_packer.sv -----
// top level of the skyline contour packer: sequencer over a ring of segment cells
//
// channel  dir  tdata (low bit up)                         tuser
// s_*      in   block_x, block_width, block_height, pad 3  restart
// m_*      out  block_y, bound_right, bound_top, pad 3     store_overflow
//
// each item runs a scan of all cells for the level, a pass over every cell to
// cut and rebuild, then, unless the store overflowed, a pad shift of the
// rebuilt list up to MAX_SEGMENTS entries and a parallel commit
// rst (synchronous) loads the ground segment into cell 0 and clears the box
// a finished result waits in the output register; the next transfer is taken
// once the sequencer is back in idle
module skyline_contour_packer import skcp_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // block_x, block_width, block_height
  input  logic [0:0]  s_tuser,   // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // block_y, bound_right, bound_top
  output logic [0:0]  m_tuser    // store_overflow
);

  localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned NW = $clog2(MAX_SEGMENTS + 1) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SEGMENTS - 1);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_SEGMENTS);

  state_t state, state_next;

  // latched item
  coord_t bx, bend, bh;
  coord_t y, top;
  coord_t max_right, max_top;
  logic   over, placed;

  logic [IW-1:0] idx;
  logic [1:0]    phase;
  logic [NW-1:0] cnt;          // segments pushed into the rebuilt list

  piece_t pc;                  // piece staged for the merge stage
  piece_t pend;                // last piece, still open for merging
  seg_t   push_seg;

  cell_ctrl_t ctrl;
  seg_t old_row [MAX_SEGMENTS];
  seg_t new_row [MAX_SEGMENTS];

  // the row of cells: old list rotates toward cell 0, new list fills from the tail
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    seg_t gnd, oin, nin;
    if (i == 0) begin : g_head
      assign gnd = '{start: '0, level: '0, length: COORD_MAX};
    end else begin : g_body
      assign gnd = '0;
    end
    if (i == MAX_SEGMENTS - 1) begin : g_tail
      assign oin = old_row[0];
      assign nin = push_seg;
    end else begin : g_mid
      assign oin = old_row[i+1];
      assign nin = new_row[i+1];
    end
    skcp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .ground_seg (gnd),
      .old_in     (oin),
      .new_in     (nin),
      .old_seg    (old_row[i]),
      .new_seg    (new_row[i])
    );
  end

  // head cell geometry
  seg_t        hd;
  logic [CW:0] hd_end;
  logic        hd_hit, disj;
  logic        accept;

  assign hd     = old_row[0];
  assign hd_end = {1'b0, hd.start} + {1'b0, hd.length};
  assign hd_hit = (hd.length != '0) && (hd.start < bend) && (hd_end > {1'b0, bx});
  assign disj   = (hd_end <= {1'b0, bx}) || (hd.start >= bend);
  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !rst;

  // piece for the current phase of the head segment
  piece_t blk, piece;
  logic   set_placed;
  always_comb begin
    blk = '{valid: 1'b1, seg: '{start: bx, level: top, length: bend - bx}};
    piece = '0;
    set_placed = 1'b0;
    if (hd.length != '0) begin
      case (phase)
        2'd0: begin
          if (disj) begin
            if (!placed && hd.start >= bx) begin
              piece = blk;
              set_placed = 1'b1;
            end
          end else if (hd.start < bx) begin
            piece = '{valid: 1'b1, seg: '{start: hd.start, level: hd.level,
                                          length: bx - hd.start}};
          end
        end
        2'd1: begin
          if (disj) begin
            piece = '{valid: 1'b1, seg: hd};
          end else if (!placed) begin
            piece = blk;
            set_placed = 1'b1;
          end
        end
        2'd2: begin
          if (!disj && hd_end > {1'b0, bend}) begin
            piece = '{valid: 1'b1, seg: '{start: bend, level: hd.level,
                                          length: CW'(hd_end - {1'b0, bend})}};
          end
        end
        default: piece = '0;
      endcase
    end
  end

  // merge stage
  logic [CW:0] pend_end;
  logic        emit_live, merge, full;
  logic        emit_push;
  assign pend_end  = {1'b0, pend.seg.start} + {1'b0, pend.seg.length};
  assign emit_live = pc.valid && (pc.seg.length != '0) && !over;
  assign merge     = pend.valid && (pend.seg.level == pc.seg.level) &&
                     (pend_end == {1'b0, pc.seg.start});
  assign full      = (cnt + NW'(pend.valid)) >= MAX_N;
  assign emit_push = emit_live && !merge && !full && pend.valid;

  // sequencer
  always_comb begin
    state_next  = state;
    ctrl        = '0;
    push_seg    = pend.seg;
    ctrl.ground = accept && s_tuser[0];
    case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN: begin
        ctrl.rotate = 1'b1;
        if (idx == LAST_IDX) state_next = ST_TOP;
      end
      ST_TOP:    state_next = ST_BUILD;
      ST_BUILD: begin
        ctrl.rotate = (phase == 2'd2);
        ctrl.push   = emit_push;
        if (phase == 2'd2 && idx == LAST_IDX) state_next = ST_FINBLK;
      end
      ST_FINBLK: begin
        ctrl.push  = emit_push;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        ctrl.push  = emit_push;
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        ctrl.push  = pend.valid && !over;
        state_next = over ? ST_DONE : ST_PAD;
      end
      ST_PAD: begin
        push_seg = '0;
        if (cnt < MAX_N) ctrl.push = 1'b1;
        else state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        ctrl.commit = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      max_right <= '0;
      max_top   <= '0;
      idx       <= '0;
      phase     <= '0;
      cnt       <= '0;
      over      <= 1'b0;
      placed    <= 1'b0;
      pc        <= '0;
      pend      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // staged piece: cut pieces while building, the leftover block at the end
      if (state == ST_BUILD) pc <= piece;
      else if (state == ST_FINBLK && !placed) pc <= blk;
      else pc <= '0;
      if (accept) begin
        bx     <= s_tdata[30:0];
        bend   <= sat_add(s_tdata[30:0], s_tdata[61:31]);
        bh     <= s_tdata[92:62];
        y      <= '0;
        idx    <= '0;
        phase  <= '0;
        cnt    <= '0;
        over   <= 1'b0;
        placed <= 1'b0;
        pend   <= '0;
        if (s_tuser[0]) begin
          max_right <= '0;
          max_top   <= '0;
        end
      end
      if (state == ST_SCAN) begin
        if (hd_hit && hd.level > y) y <= hd.level;
        idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      end
      if (state == ST_TOP) begin
        top <= sat_add(y, bh);
        if (bend > max_right) max_right <= bend;
        if (sat_add(y, bh) > max_top) max_top <= sat_add(y, bh);
      end
      if (state == ST_BUILD) begin
        if (set_placed) placed <= 1'b1;
        if (phase == 2'd2) begin
          phase <= '0;
          idx   <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
        end else begin
          phase <= phase + 2'd1;
        end
      end
      if ((state == ST_BUILD || state == ST_FINBLK || state == ST_DRAIN) && emit_live) begin
        if (merge) begin
          pend.seg.length <= sat_add(pend.seg.length, pc.seg.length);
        end else if (full) begin
          over <= 1'b1;
        end else begin
          pend <= pc;
        end
      end
      if (ctrl.push) cnt <= cnt + 1'b1;
      if (state == ST_FLUSH) pend.valid <= 1'b0;
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {3'b000, max_top, max_right, y};
        m_tuser  <= over;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // the rebuilt list never holds more than the row
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MAX_N)
    else $error("rebuilt list count beyond row depth");

  // commit only a complete, non-overflowed list
  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT |-> (!over && cnt == MAX_N))
    else $error("commit of an incomplete list");

  // an accepted transfer always starts the scan
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_SCAN)
    else $error("accepted transfer did not start the scan");

endmodule

// ----- verif/skyline_contour_packer_tb.sv -----
// testbench of the skyline contour packer: self-checking stream test with a skyline predictor
`timescale 1ns / 100ps

module skyline_contour_packer_tb import skcp_pkg::*;;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic   overflow;
    coord_t y;
    coord_t right;
    coord_t top;
  } placement_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic [0:0]  m_tuser;

  skyline_contour_packer #(.MAX_SEGMENTS(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predictor state: the skyline as the block should hold it
  coord_t sky_start [DEPTH];
  coord_t sky_level [DEPTH];
  coord_t sky_len [DEPTH];
  int     sky_count;
  coord_t box_right;
  coord_t box_top;

  coord_t new_start [DEPTH];
  coord_t new_level [DEPTH];
  coord_t new_len [DEPTH];
  int     new_count;
  logic   new_over;

  placement_t placements_due [$];
  int errors;
  int cycles;

  function automatic coord_t clip_add(coord_t a, coord_t b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31] ? COORD_MAX : s[30:0];
  endfunction

  function automatic void lay_ground();
    sky_start[0] = '0;
    sky_level[0] = '0;
    sky_len[0] = COORD_MAX;
    sky_count = 1;
    box_right = '0;
    box_top = '0;
  endfunction

  // append a piece to the rebuilt skyline, merging equal abutting levels
  function automatic void append_piece(coord_t b, coord_t lv, coord_t len);
    int k;
    if (len == 0 || new_over) return;
    if (new_count > 0) begin
      k = new_count - 1;
      if (new_level[k] == lv && {1'b0, new_start[k]} + {1'b0, new_len[k]} == {1'b0, b}) begin
        new_len[k] = clip_add(new_len[k], len);
        return;
      end
    end
    if (new_count >= DEPTH) begin
      new_over = 1'b1;
      return;
    end
    new_start[new_count] = b;
    new_level[new_count] = lv;
    new_len[new_count] = len;
    new_count++;
  endfunction

  function automatic placement_t place_block(logic restart, coord_t x, coord_t w, coord_t h);
    placement_t p;
    coord_t rgt, y, top;
    logic [31:0] e;
    logic placed;
    y = '0;
    placed = 1'b0;
    if (restart) lay_ground();
    rgt = clip_add(x, w);
    for (int i = 0; i < sky_count; i++) begin
      e = {1'b0, sky_start[i]} + {1'b0, sky_len[i]};
      if (sky_len[i] != 0 && sky_start[i] < rgt && e > {1'b0, x} && sky_level[i] > y)
        y = sky_level[i];
    end
    top = clip_add(y, h);
    new_count = 0;
    new_over = 1'b0;
    for (int i = 0; i < sky_count; i++) begin
      e = {1'b0, sky_start[i]} + {1'b0, sky_len[i]};
      if (sky_len[i] == 0) continue;
      if (e <= {1'b0, x} || sky_start[i] >= rgt) begin
        if (!placed && sky_start[i] >= x) begin
          append_piece(x, top, rgt - x);
          placed = 1'b1;
        end
        append_piece(sky_start[i], sky_level[i], sky_len[i]);
      end else begin
        if (sky_start[i] < x) append_piece(sky_start[i], sky_level[i], x - sky_start[i]);
        if (!placed) begin
          append_piece(x, top, rgt - x);
          placed = 1'b1;
        end
        if (e > {1'b0, rgt})
          append_piece(rgt, sky_level[i], coord_t'(e - {1'b0, rgt}));
      end
    end
    if (!placed) append_piece(x, top, rgt - x);
    if (!new_over) begin
      for (int i = 0; i < new_count; i++) begin
        sky_start[i] = new_start[i];
        sky_level[i] = new_level[i];
        sky_len[i] = new_len[i];
      end
      sky_count = new_count;
    end
    if (rgt > box_right) box_right = rgt;
    if (top > box_top) box_top = top;
    p.overflow = new_over;
    p.y = y;
    p.right = box_right;
    p.top = box_top;
    return p;
  endfunction

  task automatic report_mismatch(string what, coord_t got, coord_t want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one block; the prediction is queued as the transfer is taken
  task automatic send_block(logic restart, coord_t x, coord_t w, coord_t h);
    int gap;
    gap = $urandom_range(0, 5);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, h, w, x};
    s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
    placements_due = {placements_due, place_block(restart, x, w, h)};
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (placements_due.size() != 0) @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom_range(0, 3));
      1: return COORD_MAX - coord_t'($urandom_range(0, 3));
      2: return coord_t'($urandom());
      default: return coord_t'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic test_extremes();
    send_block(1'b1, '0, 31'd1, '0);
    send_block(1'b0, '0, COORD_MAX, COORD_MAX);
    send_block(1'b0, 31'd5, 31'd1, 31'd1);
    send_block(1'b1, COORD_MAX, 31'd1, 31'd7);
    send_block(1'b0, coord_t'(COORD_MAX - 31'd1), COORD_MAX, 31'd3);
    send_block(1'b0, 31'd10, '0, 31'd4);
    send_block(1'b1, 31'd10, 31'd10, 31'd5);
    send_block(1'b0, 31'd15, '0, 31'd1);
    send_block(1'b0, 31'd20, 31'd10, 31'd5);
    send_block(1'b0, 31'd5, 31'd30, 31'h2AAAAAAA);
    send_block(1'b0, 31'd0, 31'd100, 31'h55555555);
    send_block(1'b0, 31'd50, 31'd1, COORD_MAX);
  endtask

  // narrow blocks at fresh positions fill the store until it overflows
  task automatic test_store_overflow();
    send_block(1'b1, '0, 31'd1, 31'd1);
    for (int i = 1; i < 70; i++)
      send_block(1'b0, coord_t'(3 * i), 31'd1, coord_t'(i + 1));
    send_block(1'b0, 31'd500, 31'd1, 31'd2);
  endtask

  task automatic test_random_packing();
    logic r;
    coord_t x, w;
    for (int i = 0; i < 320; i++) begin
      r = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 9) < 8) begin
        x = coord_t'($urandom_range(0, 400));
        w = coord_t'($urandom_range(1, 60));
        send_block(r, x, w, coord_t'($urandom_range(0, 50)));
      end else begin
        send_block(r, rand_coord(), rand_coord(), rand_coord());
      end
      // hold off now and then until the block has caught up
      if (i % 100 == 50) wait_drained();
    end
  endtask

  // result checker with random stalls on the output side
  initial begin
    int stall;
    placement_t want;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (placements_due.size() == 0) begin
        report_mismatch("result count", coord_t'(1), coord_t'(0));
      end else begin
        want = placements_due.pop_front();
        if (m_tdata[30:0] !== want.y) report_mismatch("block_y", m_tdata[30:0], want.y);
        if (m_tdata[61:31] !== want.right)
          report_mismatch("bound_right", m_tdata[61:31], want.right);
        if (m_tdata[92:62] !== want.top) report_mismatch("bound_top", m_tdata[92:62], want.top);
        if (m_tuser[0] !== want.overflow)
          report_mismatch("store_overflow", coord_t'(m_tuser[0]), coord_t'(want.overflow));
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("skyline_contour_packer_tb failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    lay_ground();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_store_overflow();
    test_random_packing();
    wait_drained();
    repeat (5 * DEPTH + 20) @(negedge clk);
    if (errors == 0 && placements_due.size() == 0) begin
      $display("skyline_contour_packer_tb passed");
    end else begin
      $display("skyline_contour_packer_tb failed");
    end
    $finish;
  end

endmodule
